// ----- sv/owfa_pkg.sv -----
// ----------------------------------------------------------------------------
// owfa_pkg: shared types and constants
// Widths, request/status codes, the control FSM state type and the per-cell
// control struct for the overwrite FIFO with window average.
// ----------------------------------------------------------------------------
package owfa_pkg;

  localparam int DEPTH     = 5;
  localparam int HANDLE_W  = 16;
  localparam int YEAR_W    = 13;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W     = YEAR_W + CNT_W;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MAG_W     = DIV_STEPS * DIGIT_W;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DIV  = 1'b1
  } fsm_e_t;

  typedef struct packed {
    logic load;   // take the incoming request's entry
    logic shift;  // take the entry of the next-younger cell
  } cell_ctrl_t;

endpackage

// ----- sv/owfa_cell.sv -----
// ----------------------------------------------------------------------------
// owfa_cell: one FIFO entry
// Holds a handle and a year; loads a new entry or shifts in its neighbor's.
// ----------------------------------------------------------------------------
module owfa_cell (
  input  logic                                clk,
  input  owfa_pkg::cell_ctrl_t                ctrl,
  input  logic        [owfa_pkg::HANDLE_W-1:0] nb_handle,
  input  logic signed [owfa_pkg::YEAR_W-1:0]   nb_year,
  input  logic        [owfa_pkg::HANDLE_W-1:0] new_handle,
  input  logic signed [owfa_pkg::YEAR_W-1:0]   new_year,
  output logic        [owfa_pkg::HANDLE_W-1:0] handle,
  output logic signed [owfa_pkg::YEAR_W-1:0]   year
);
  import owfa_pkg::*;

  logic        [HANDLE_W-1:0] handle_r;
  logic signed [YEAR_W-1:0]   year_r;

  // load wins: on an insert into a full queue the tail cell loads
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      handle_r <= new_handle;
      year_r   <= new_year;
    end else if (ctrl.shift) begin
      handle_r <= nb_handle;
      year_r   <= nb_year;
    end
  end

  assign handle = handle_r;
  assign year   = year_r;

endmodule

// ----- sv/owfa_div.sv -----
// ----------------------------------------------------------------------------
// owfa_div: iterative signed-by-count divider
// Restoring division, DIGIT_W quotient bits per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module owfa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [owfa_pkg::SUM_W-1:0]        sum_i,
  input  logic [owfa_pkg::CNT_W-1:0]        cnt_i,
  output logic                              done,
  output logic signed [owfa_pkg::YEAR_W-1:0] quo
);
  import owfa_pkg::*;

  logic               busy_r, prep_r, done_r, neg_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   dvs_r;
  logic [CNT_W:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]   q_r, q_nxt, q_signed;
  logic [SUM_W-1:0]   mag;

  assign mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // DIGIT_W restoring steps on a narrow remainder
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    for (int k = 0; k < DIGIT_W; k++) begin
      rem_nxt = {rem_nxt[CNT_W-1:0], q_nxt[MAG_W-1]};
      q_nxt   = {q_nxt[MAG_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt  = rem_nxt - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      prep_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (prep_r) begin
        prep_r <= 1'b0;
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum_i;
      dvs_r <= cnt_i;
    end else if (busy_r) begin
      if (prep_r) begin
        neg_r <= sum_r[SUM_W-1];
        q_r   <= MAG_W'(mag);
        rem_r <= '0;
      end else begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign quo      = q_signed[YEAR_W-1:0];
  assign done     = done_r;

endmodule

// ----- sv/overwrite_fifo_window_average.sv -----
// ----------------------------------------------------------------------------
// overwrite_fifo_window_average: bounded FIFO with running mean of years
// Top level: cell chain, fill count, running sum, divider and result register.
// ----------------------------------------------------------------------------
// A FIFO of DEPTH entries (handle + signed year). An insert into a full queue
// drops the oldest entry, appends the new one and returns the truncated mean
// of all stored years. A remove returns the oldest entry, or status EMPTY when
// nothing is stored (no state change). Each request gives one result. Removes
// are answered in the cycle after acceptance; an insert's mean comes from the
// divider, which retires DIGIT_W quotient bits per cycle after a sign/magnitude
// prep step. A new request is taken only when the output register is empty
// or its result is taken at the same edge; a result held by out_stall stalls
// the request side, and in_stall stays high while an insert's mean is being
// computed. No clearing pass after reset; entries are only read below the
// fill count.
// ----------------------------------------------------------------------------
module overwrite_fifo_window_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic        [owfa_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic signed [owfa_pkg::YEAR_W-1:0]   in_year_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [1:0]                   out_status,
  output logic signed [owfa_pkg::YEAR_W-1:0]   out_mean_year,
  output logic        [owfa_pkg::HANDLE_W-1:0] out_removed_handle,
  output logic signed [owfa_pkg::YEAR_W-1:0]   out_removed_year
);
  import owfa_pkg::*;

  // control state
  fsm_e_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;

  // request decode
  logic               acc, acc_ins, acc_rem, full, empty;
  logic [IDX_W-1:0]   wr_idx;
  logic [SUM_W-1:0]   year_in_ext, year_old_ext;

  // cell chain
  cell_ctrl_t                ctrl   [DEPTH];
  logic        [HANDLE_W-1:0] c_handle[DEPTH];
  logic signed [YEAR_W-1:0]   c_year  [DEPTH];

  // divider
  logic                      div_done;
  logic signed [YEAR_W-1:0]  div_quo;

  // output register
  logic                      out_free, load_div;
  logic                      out_valid_r;
  status_e_t                 out_status_r;
  logic signed [YEAR_W-1:0]  out_mean_r, out_ryear_r;
  logic [HANDLE_W-1:0]       out_rhandle_r;

  assign out_free = !out_valid_r || !out_stall;
  assign acc      = in_valid && !in_stall;
  assign acc_ins  = acc && (in_req_type == REQ_INSERT);
  assign acc_rem  = acc && (in_req_type == REQ_REMOVE);
  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign wr_idx   = full ? IDX_W'(DEPTH - 1) : fill_r[IDX_W-1:0];

  // ---- FSM: next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (acc_ins) state_nxt = FSM_DIV;
      FSM_DIV:  if (div_done && out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // ---- FSM: outputs ----
  always_comb begin
    in_stall = 1'b1;
    load_div = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_stall = !out_free;
      FSM_DIV:  load_div = div_done && out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  // ---- cell chain: entry 0 is the oldest ----
  // Every cell shifts toward the head on a drop; the write slot loads.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].shift = (acc_ins && full) || (acc_rem && !empty);
    assign ctrl[i].load  = acc_ins && (wr_idx == IDX_W'(i));

    if (i < DEPTH - 1) begin : g_mid
      owfa_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[i]),
        .nb_handle  (c_handle[i+1]),
        .nb_year    (c_year[i+1]),
        .new_handle (in_entry_handle),
        .new_year   (in_year_value),
        .handle     (c_handle[i]),
        .year       (c_year[i])
      );
    end else begin : g_tail
      // tail shifts in don't-care data; it lies beyond the fill count
      owfa_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[i]),
        .nb_handle  (in_entry_handle),
        .nb_year    (in_year_value),
        .new_handle (in_entry_handle),
        .new_year   (in_year_value),
        .handle     (c_handle[i]),
        .year       (c_year[i])
      );
    end
  end

  // ---- fill count and running sum of stored years ----
  assign year_in_ext  = {{CNT_W{in_year_value[YEAR_W-1]}}, in_year_value};
  assign year_old_ext = {{CNT_W{c_year[0][YEAR_W-1]}}, c_year[0]};

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (acc_ins) begin
      if (full) begin
        sum_nxt = sum_r + year_in_ext - year_old_ext;
      end else begin
        fill_nxt = fill_r + 1'b1;
        sum_nxt  = sum_r + year_in_ext;
      end
    end else if (acc_rem && !empty) begin
      fill_nxt = fill_r - 1'b1;
      sum_nxt  = sum_r - year_old_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      fill_r  <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // mean = new sum / new count, count is at least one after an insert
  owfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc_ins),
    .sum_i (sum_nxt),
    .cnt_i (fill_nxt),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_rem || load_div) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      out_status_r  <= ST_INSERTED;
      out_mean_r    <= div_quo;
      out_rhandle_r <= '0;
      out_ryear_r   <= '0;
    end else if (acc_rem) begin
      out_status_r  <= empty ? ST_EMPTY : ST_REMOVED;
      out_mean_r    <= '0;
      out_rhandle_r <= empty ? '0 : c_handle[0];
      out_ryear_r   <= empty ? '0 : c_year[0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_mean_year      = out_mean_r;
  assign out_removed_handle = out_rhandle_r;
  assign out_removed_year   = out_ryear_r;

  // ---- assertions ----
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_rem && !empty) |=> (fill_r == $past(fill_r) - 1'b1))
    else $error("remove did not drop one entry");

  a_insert_div: assert property (@(posedge clk) disable iff (!rst_n)
    acc_ins |=> (state_r == FSM_DIV && !div_done))
    else $error("insert did not start a fresh division");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |->
      (out_mean_r == '0 && out_rhandle_r == '0 && out_ryear_r == '0))
    else $error("empty-queue result carries data");

endmodule

// ----- tb/overwrite_fifo_window_average_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_fifo_window_average_tb: request/result checker for the overwrite
// FIFO with window average
// Drives inserts and removes through the valid/stall request port and keeps
// its own copy of the queue. Every result is compared field by field with the
// prediction. Traffic runs under several idle/stall mixes, with a long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module overwrite_fifo_window_average_tb;
  import owfa_pkg::*;

  localparam int CYCLE_LIMIT    = 500_000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES    = 20;   // well past the insert latency
  localparam int PHASE_ITEMS    = 250;

  // One expected result, laid out like the output port.
  typedef struct {
    status_e_t                   status;
    logic signed [YEAR_W-1:0]    mean_year;
    logic        [HANDLE_W-1:0]  handle;
    logic signed [YEAR_W-1:0]    year;
  } fifo_result_t;

  // Scoreboard: mirrors the queue contents and holds the expected results in
  // request order.
  class fifo_mean_tracker;
    logic [HANDLE_W-1:0] held_handles[$];
    int                  held_years[$];
    fifo_result_t        expected_results[$];
    int                  failures = 0;

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(req_e_t kind, logic [HANDLE_W-1:0] handle,
                               logic signed [YEAR_W-1:0] year);
      fifo_result_t r;
      int           sum;
      r.status    = ST_INSERTED;
      r.mean_year = '0;
      r.handle    = '0;
      r.year      = '0;
      sum         = 0;
      if (kind == REQ_INSERT) begin
        // full queue: oldest entry falls out before the append
        if (held_handles.size() >= DEPTH) begin
          void'(held_handles.pop_front());
          void'(held_years.pop_front());
        end
        held_handles.push_back(handle);
        held_years.push_back(int'(year));
        foreach (held_years[i]) sum += held_years[i];
        // int division truncates toward zero
        r.mean_year = YEAR_W'(sum / held_years.size());
      end else if (held_handles.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.handle = held_handles.pop_front();
        r.year   = YEAR_W'(held_years.pop_front());
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [YEAR_W-1:0] mean_year,
                               logic [HANDLE_W-1:0] handle,
                               logic signed [YEAR_W-1:0] year);
      fifo_result_t r;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with nothing outstanding: status %0d mean %0d handle %0h year %0d",
                 $time, status, mean_year, handle, year);
        return;
      end
      r = expected_results.pop_front();
      if (status !== r.status) begin
        failures++;
        $display("%0t: status expected %0d, got %0d", $time, r.status, status);
      end
      if (mean_year !== r.mean_year) begin
        failures++;
        $display("%0t: mean_year expected %0d, got %0d", $time, r.mean_year, mean_year);
      end
      if (handle !== r.handle) begin
        failures++;
        $display("%0t: removed_handle expected %0h, got %0h", $time, r.handle, handle);
      end
      if (year !== r.year) begin
        failures++;
        $display("%0t: removed_year expected %0d, got %0d", $time, r.year, year);
      end
    endfunction
  endclass

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic                        in_req_type     = 1'b0;
  logic        [HANDLE_W-1:0]  in_entry_handle = '0;
  logic signed [YEAR_W-1:0]    in_year_value   = '0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic        [1:0]           out_status;
  logic signed [YEAR_W-1:0]    out_mean_year;
  logic        [HANDLE_W-1:0]  out_removed_handle;
  logic signed [YEAR_W-1:0]    out_removed_year;

  // Traffic shaping, written only by the main sequence.
  int idle_pct      = 0;
  int stall_pct     = 0;
  int holdoff_asked = 0;
  // Receiver-owned hold-off bookkeeping.
  int holdoff_served = 0;
  int holdoff_left   = 0;
  int cycle_count    = 0;

  fifo_mean_tracker tracker = new();

  overwrite_fifo_window_average dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_entry_handle   (in_entry_handle),
    .in_year_value     (in_year_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_mean_year     (out_mean_year),
    .out_removed_handle(out_removed_handle),
    .out_removed_year  (out_removed_year)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver. A hold-off request keeps out_stall high for a fixed count so the
  // block backs up and pushes back on the request side; otherwise stall at the
  // phase's rate.
  always @(negedge clk) begin
    if (holdoff_served < holdoff_asked) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_served++;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Both handshakes are sampled on the rising edge. The result is checked
  // before the request of the same edge is noted, so a request never
  // matches its own result early.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result(out_status, out_mean_year, out_removed_handle,
                             out_removed_year);
      if (in_valid && !in_stall)
        tracker.note_request(req_e_t'(in_req_type), in_entry_handle, in_year_value);
    end
  end

  // Offer one request; returns on the edge that accepts it. in_valid stays
  // high so back-to-back requests see no gap unless the idle draw says so.
  task automatic send_request(req_e_t kind, logic [HANDLE_W-1:0] handle,
                              logic signed [YEAR_W-1:0] year);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_entry_handle <= handle;
    in_year_value   <= year;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, then wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // Mostly in-range years, with some raw 13-bit patterns so every bit flips.
  function automatic logic signed [YEAR_W-1:0] pick_year();
    int v;
    if ($urandom_range(9) == 0)
      return YEAR_W'($urandom);
    v = $urandom_range(4096);
    return YEAR_W'(v - 1);
  endfunction

  // Random requests. The insert share moves every 50 requests so the queue
  // swings between empty and full and sits at both ends for a while.
  task automatic run_random(int count);
    int     insert_pct;
    req_e_t kind;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      send_request(kind, HANDLE_W'($urandom), pick_year());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: remove on empty, field extremes, overwrite of the oldest
    // entry when full, draining to empty, negative mean truncation.
    send_request(REQ_REMOVE, 16'hFFFF, 13'sd0);
    send_request(REQ_INSERT, 16'h0000, 13'sd0);
    send_request(REQ_INSERT, 16'hFFFF, 13'sd4095);
    send_request(REQ_INSERT, 16'hA5A5, -13'sd4096);
    send_request(REQ_INSERT, 16'h5A5A, -13'sd1);
    send_request(REQ_INSERT, 16'h0001, 13'sd4095);   // queue now full
    send_request(REQ_INSERT, 16'h0002, -13'sd4096);  // drops the oldest
    send_request(REQ_INSERT, 16'h0003, -13'sd1);
    repeat (DEPTH) send_request(REQ_REMOVE, 16'h0000, 13'sd0);
    send_request(REQ_REMOVE, 16'h0000, 13'sd0);      // empty again
    send_request(REQ_INSERT, 16'h0007, -13'sd7);
    send_request(REQ_INSERT, 16'h0008, 13'sd2);      // -5/2 -> -2
    send_request(REQ_INSERT, 16'h0009, -13'sd1);     // -6/3 -> -2
    repeat (3) send_request(REQ_REMOVE, 16'h0000, 13'sd0);
    drain_results();

    // No idling, with a long receiver hold-off at the start while requests
    // keep coming.
    holdoff_asked++;
    run_random(PHASE_ITEMS);
    drain_results();

    idle_pct  = 77;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
    drain_results();

    idle_pct  = 0;
    stall_pct = 77;
    run_random(PHASE_ITEMS);
    drain_results();

    idle_pct  = 24;
    stall_pct = 24;
    run_random(PHASE_ITEMS);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
